### rtl/core/mqr_pkg.sv
// Shared types and constants for the matrix quarter-turn rotator.
package mqr_pkg;

	// Fixed field widths of the channels and the configuration port
	localparam int ELEM_W     = 32;
	localparam int VALUE_W    = 32;
	localparam int DIM_FLD_W  = 7;
	localparam int ROT_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION  = 2'd2;

	// Item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	// Result status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_READY = 1'b1;

	// Rotation codes (clockwise)
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_READ,
		S_PUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_en;
		logic emit_start;
		logic addr_en;
		logic rd_en;
		logic out_load;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic loaded_full;
	} dp_sts_t;

endpackage

### rtl/core/mqr_channels.sv
// Valid/ready channel interfaces for input items and result items.
interface mqr_item_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [mqr_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface mqr_result_if;
	logic                           valid;
	logic                           ready;
	logic [mqr_pkg::ELEM_W-1:0]     elem_out;
	logic [mqr_pkg::DIM_FLD_W-1:0]  out_width;
	logic [mqr_pkg::DIM_FLD_W-1:0]  out_height;
	logic                           last;
	logic                           status;

	modport source (output valid, output elem_out, output out_width, output out_height,
		output last, output status, input ready);
	modport sink   (input valid, input elem_out, input out_width, input out_height,
		input last, input status, output ready);
endinterface

### rtl/core/mqr_ctrl.sv
// Sequencing state machine: item acceptance, emit steps and output slot.
module mqr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_cmd,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mqr_pkg::ctrl_cmd_t  ctl,
	input  mqr_pkg::dp_sts_t    sts
);

	mqr_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            accept;
	logic            slot_free;

	assign accept    = in_valid && (state_q == mqr_pkg::S_IDLE);
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mqr_pkg::S_IDLE: begin
				if (accept && in_cmd == mqr_pkg::CMD_EMIT) begin
					state_d = sts.loaded_full ? mqr_pkg::S_ADDR : mqr_pkg::S_PUT;
				end
			end
			mqr_pkg::S_ADDR: state_d = mqr_pkg::S_READ;
			mqr_pkg::S_READ: state_d = mqr_pkg::S_PUT;
			mqr_pkg::S_PUT: begin
				if (slot_free) begin
					state_d = mqr_pkg::S_IDLE;
				end
			end
			default: state_d = mqr_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready       = (state_q == mqr_pkg::S_IDLE);
		ctl.load_en    = accept && (in_cmd == mqr_pkg::CMD_LOAD);
		ctl.emit_start = accept && (in_cmd == mqr_pkg::CMD_EMIT);
		ctl.addr_en    = (state_q == mqr_pkg::S_ADDR);
		ctl.rd_en      = (state_q == mqr_pkg::S_READ);
		ctl.out_load   = (state_q == mqr_pkg::S_PUT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mqr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/mqr_datapath.sv
// Element store, load/emit counters, rotated address generation and result register.
module mqr_datapath #(
	parameter int MAX_DIM   = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mqr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mqr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [mqr_pkg::VALUE_W-1:0]        value,
	input  mqr_pkg::ctrl_cmd_t                 ctl,
	output mqr_pkg::dp_sts_t                   sts,
	output logic [mqr_pkg::ELEM_W-1:0]         elem_out,
	output logic [mqr_pkg::DIM_FLD_W-1:0]      out_width,
	output logic [mqr_pkg::DIM_FLD_W-1:0]      out_height,
	output logic                               last,
	output logic                               status
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = POS_W + DIM_W + 1;
	localparam logic [DIM_W-1:0] ONE_D = DIM_W'(1);

	// clamp a dimension register into 1..MAX_DIM
	function automatic logic [DIM_W-1:0] eff_dim(input logic [mqr_pkg::DIM_FLD_W-1:0] v);
		logic [8:0] vx;
		logic [8:0] r;
		vx = {2'b00, v};
		if (vx == 9'd0) begin
			r = 9'd1;
		end else if (vx > 9'(MAX_DIM)) begin
			r = 9'(MAX_DIM);
		end else begin
			r = vx;
		end
		return r[DIM_W-1:0];
	endfunction

	// configuration
	logic [mqr_pkg::DIM_FLD_W-1:0] in_width_q, in_height_q;
	logic [mqr_pkg::ROT_W-1:0]     rot_q;

	// counters
	logic [POS_W-1:0] ld_col_q, ld_row_q, em_col_q, em_row_q;
	logic [AW-1:0]    ld_addr_q;
	logic             full_q;

	// emit pipeline
	logic [POS_W-1:0]     x_s1, y_s1;
	logic                 last_s1, nr_s1;
	logic [AW-1:0]        addr_s2;
	logic [WORD_BITS-1:0] rd_s3;

	logic [WORD_BITS-1:0] mem [DEPTH];

	logic [DIM_W-1:0] w_eff, h_eff, ow, oh;
	logic [DIM_W-1:0] w_m1, h_m1, ow_m1, oh_m1;
	logic [DIM_W-1:0] r_d, c_d, x_d, y_d;
	logic             ld_col_end, ld_row_end, em_col_end, em_row_end;
	logic [LW-1:0]    lin;
	logic [WORD_BITS+mqr_pkg::VALUE_W-1:0] wr_ext;
	logic [WORD_BITS+mqr_pkg::ELEM_W-1:0]  rd_ext;
	logic [DIM_W+mqr_pkg::DIM_FLD_W-1:0]   ow_ext, oh_ext;
	logic             cfg_dim_wr, cfg_rot_wr;

	assign w_eff = eff_dim(in_width_q);
	assign h_eff = eff_dim(in_height_q);
	assign ow    = rot_q[0] ? h_eff : w_eff;
	assign oh    = rot_q[0] ? w_eff : h_eff;
	assign w_m1  = w_eff - ONE_D;
	assign h_m1  = h_eff - ONE_D;
	assign ow_m1 = ow - ONE_D;
	assign oh_m1 = oh - ONE_D;

	assign ld_col_end = (DIM_W'(ld_col_q) == w_m1);
	assign ld_row_end = (DIM_W'(ld_row_q) == h_m1);
	assign em_col_end = (DIM_W'(em_col_q) == ow_m1);
	assign em_row_end = (DIM_W'(em_row_q) == oh_m1);

	assign r_d = DIM_W'(em_row_q);
	assign c_d = DIM_W'(em_col_q);

	// source coordinates of the next rotated element
	always_comb begin
		unique case (rot_q)
			mqr_pkg::ROT_90: begin
				x_d = r_d;
				y_d = h_m1 - c_d;
			end
			mqr_pkg::ROT_180: begin
				x_d = w_m1 - c_d;
				y_d = h_m1 - r_d;
			end
			mqr_pkg::ROT_270: begin
				x_d = w_m1 - r_d;
				y_d = c_d;
			end
			default: begin
				x_d = c_d;
				y_d = r_d;
			end
		endcase
	end

	assign lin    = LW'(y_s1) * LW'(w_eff) + LW'(x_s1);
	assign wr_ext = {{WORD_BITS{1'b0}}, value};
	assign rd_ext = {{mqr_pkg::ELEM_W{1'b0}}, rd_s3};
	assign ow_ext = {{mqr_pkg::DIM_FLD_W{1'b0}}, ow};
	assign oh_ext = {{mqr_pkg::DIM_FLD_W{1'b0}}, oh};

	assign cfg_dim_wr = cfg_we && (cfg_index == mqr_pkg::REG_IN_WIDTH ||
		cfg_index == mqr_pkg::REG_IN_HEIGHT);
	assign cfg_rot_wr = cfg_we && (cfg_index == mqr_pkg::REG_ROTATION);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q  <= mqr_pkg::DIM_FLD_W'(1);
			in_height_q <= mqr_pkg::DIM_FLD_W'(1);
			rot_q       <= mqr_pkg::ROT_0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mqr_pkg::REG_IN_WIDTH:  in_width_q  <= cfg_data;
				mqr_pkg::REG_IN_HEIGHT: in_height_q <= cfg_data;
				mqr_pkg::REG_ROTATION:  rot_q       <= cfg_data[mqr_pkg::ROT_W-1:0];
				default: ;
			endcase
		end
	end

	// load and emit positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_col_q  <= '0;
			ld_row_q  <= '0;
			ld_addr_q <= '0;
			full_q    <= 1'b0;
			em_col_q  <= '0;
			em_row_q  <= '0;
		end else begin
			priority if (cfg_dim_wr) begin
				ld_col_q  <= '0;
				ld_row_q  <= '0;
				ld_addr_q <= '0;
				full_q    <= 1'b0;
				em_col_q  <= '0;
				em_row_q  <= '0;
			end else if (cfg_rot_wr) begin
				em_col_q <= '0;
				em_row_q <= '0;
			end else if (ctl.load_en && !full_q) begin
				ld_addr_q <= ld_addr_q + AW'(1);
				if (ld_col_end) begin
					ld_col_q <= '0;
					if (ld_row_end) begin
						full_q <= 1'b1;
					end else begin
						ld_row_q <= ld_row_q + POS_W'(1);
					end
				end else begin
					ld_col_q <= ld_col_q + POS_W'(1);
				end
			end else if (ctl.emit_start && full_q) begin
				if (em_col_end && em_row_end) begin
					// whole matrix sent: back to loading
					ld_col_q  <= '0;
					ld_row_q  <= '0;
					ld_addr_q <= '0;
					full_q    <= 1'b0;
					em_col_q  <= '0;
					em_row_q  <= '0;
				end else if (em_col_end) begin
					em_col_q <= '0;
					em_row_q <= em_row_q + POS_W'(1);
				end else begin
					em_col_q <= em_col_q + POS_W'(1);
				end
			end else begin
			end
		end
	end

	// emit pipeline and result payload
	always_ff @(posedge clk) begin
		if (ctl.emit_start) begin
			x_s1    <= x_d[POS_W-1:0];
			y_s1    <= y_d[POS_W-1:0];
			last_s1 <= em_col_end && em_row_end;
			nr_s1   <= !full_q;
		end
		if (ctl.addr_en) begin
			addr_s2 <= lin[AW-1:0];
		end
		if (ctl.out_load) begin
			elem_out   <= nr_s1 ? '0 : rd_ext[mqr_pkg::ELEM_W-1:0];
			out_width  <= ow_ext[mqr_pkg::DIM_FLD_W-1:0];
			out_height <= oh_ext[mqr_pkg::DIM_FLD_W-1:0];
			last       <= nr_s1 ? 1'b0 : last_s1;
			status     <= nr_s1 ? mqr_pkg::STATUS_NOT_READY : mqr_pkg::STATUS_OK;
		end
	end

	// element store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.load_en && !full_q) begin
			mem[ld_addr_q] <= wr_ext[WORD_BITS-1:0];
		end
		if (ctl.rd_en) begin
			rd_s3 <= mem[addr_s2];
		end
	end

	assign sts.loaded_full = full_q;

endmodule

### rtl/core/matrix_quarter_turn_rotator_unit.sv
// Top level of the matrix quarter-turn rotator: controller, datapath and checks.
//
//  channel  | dir  | handshake        | payload
//  ---------+------+------------------+----------------------------------------------
//  items    | sink | valid / ready    | cmd (load/emit), value[31:0]
//  results  | src  | valid / ready    | elem_out[31:0], out_width, out_height,
//           |      |                  | last, status
//  cfg      | sink | cfg_we, no ready | cfg_index[1:0], cfg_data[6:0]
//
//  A load beat puts its word straight into the element store and the input stays ready.
//  An emit beat passes through the coordinate, address multiply, store read and result
//  register steps, with the address multiply and the store read both registered; a
//  not-ready emit goes from the coordinate step straight to the result register.
//  The result register frees the input side: a new beat is taken while a result waits,
//  but an emit stays in the result stage until the register is free.
//  Reset clears the configuration (1 x 1, no rotation) and all counters; the store is
//  left as it is and needs no clearing pass.
module matrix_quarter_turn_rotator_unit #(
	parameter int MAX_DIM   = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mqr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mqr_pkg::CFG_DATA_W-1:0] cfg_data,
	mqr_item_if.sink                       items,
	mqr_result_if.source                   results
);

	mqr_pkg::ctrl_cmd_t ctl;
	mqr_pkg::dp_sts_t   sts;

	// sequencing
	mqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_cmd    (items.cmd),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// store, counters and result register
	mqr_datapath #(
		.MAX_DIM   (MAX_DIM),
		.WORD_BITS (WORD_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.value      (items.value),
		.ctl        (ctl),
		.sts        (sts),
		.elem_out   (results.elem_out),
		.out_width  (results.out_width),
		.out_height (results.out_height),
		.last       (results.last),
		.status     (results.status)
	);

	// a not-ready result carries no element and never closes the matrix
	a_not_ready_clean: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.status == mqr_pkg::STATUS_NOT_READY |->
			results.last == 1'b0 && results.elem_out == '0)
		else $error("not-ready result carries data or last");

	// an accepted emit blocks further beats until its result is registered
	a_emit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.cmd == mqr_pkg::CMD_EMIT |=> !items.ready)
		else $error("input taken while an emit is in flight");

	// loading the result register always presents a beat
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> results.valid)
		else $error("result register loaded but no valid beat");

endmodule

### tb/testbench.sv
// Self-checking testbench for the matrix quarter-turn rotator: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
	import mqr_pkg::*;

	// Geometry of the block as built here
	localparam int DIM_MAX     = 64;
	localparam int STORE_WORDS = DIM_MAX * DIM_MAX;

	// Index 3 is not decoded by the block; writes to it must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Cycles to let a load beat clear the pipeline once no result is pending
	localparam int SETTLE     = 8;
	// Random beats wanted before stopping, and the point where idling and stalling stop
	localparam int BEAT_GOAL  = 1050;
	localparam int CALM_FROM  = 900;
	// Hard stop, far beyond the slowest legal run
	localparam int LIMIT_NS   = 5_000_000;
	localparam int PRINT_MAX  = 50;

	// One rotated element as it leaves the block
	typedef struct packed {
		logic [ELEM_W-1:0]    elem;
		logic [DIM_FLD_W-1:0] width;
		logic [DIM_FLD_W-1:0] height;
		logic                 last;
		logic                 status;
	} rot_res_t;

	typedef enum logic {
		ROW_REG,
		ROW_BEAT
	} row_kind_t;

	// One line of the directed table: a register write or an item beat
	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  cmd;
		logic [VALUE_W-1:0]    value;
		bit                    typed;
		rot_res_t              want;
	} plan_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mqr_item_if   item_ch ();
	mqr_result_if res_ch ();

	matrix_quarter_turn_rotator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (item_ch),
		.results   (res_ch)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the rotator: registers, element store, fill and
	// read-out position
	// ------------------------------------------------------------------
	logic [ELEM_W-1:0]    mat_store [STORE_WORDS];
	logic [DIM_FLD_W-1:0] m_width;
	logic [DIM_FLD_W-1:0] m_height;
	logic [ROT_W-1:0]     m_rot;
	int unsigned          fill_count;
	int unsigned          out_row;
	int unsigned          out_col;
	bit                   mat_full;

	rot_res_t    rotated_elem_q [$];
	plan_row_t   plan_q [$];
	int unsigned n_fail;
	int unsigned n_beats;
	bit          tx_idle_on;
	bit          rx_stall_on;
	bit          calm;

	// Width or height as the block uses it: 0 counts as 1, above 64 as 64
	function automatic int unsigned clamp_dim(input logic [DIM_FLD_W-1:0] d);
		if (d == '0)
			return 1;
		if (d > DIM_MAX)
			return DIM_MAX;
		return d;
	endfunction

	function automatic void restart_fill();
		fill_count = 0;
		mat_full   = 1'b0;
		out_row    = 0;
		out_col    = 0;
	endfunction

	function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_IN_WIDTH: begin
				m_width = data;
				restart_fill();
			end
			REG_IN_HEIGHT: begin
				m_height = data;
				restart_fill();
			end
			REG_ROTATION: begin
				// data is kept, read-out starts again from the top
				m_rot   = data[ROT_W-1:0];
				out_row = 0;
				out_col = 0;
			end
			default: ;
		endcase
	endfunction

	// Applies one accepted beat to the shadow state. A load yields nothing
	// (stored says whether it landed); an emit yields one element.
	function automatic void predict_rotation(input logic cmd, input logic [VALUE_W-1:0] value,
			output bit produces, output bit stored, output rot_res_t res);
		int unsigned w, h, ow, oh, r, c, x, y;
		bit          fin;
		w        = clamp_dim(m_width);
		h        = clamp_dim(m_height);
		ow       = m_rot[0] ? h : w;
		oh       = m_rot[0] ? w : h;
		produces = 1'b0;
		stored   = 1'b0;
		res      = '0;
		if (cmd == CMD_LOAD) begin
			if (!mat_full && fill_count < w * h) begin
				mat_store[fill_count] = value;
				fill_count++;
				stored = 1'b1;
				if (fill_count >= w * h)
					mat_full = 1'b1;
			end
			return;
		end
		produces   = 1'b1;
		res.width  = ow[DIM_FLD_W-1:0];
		res.height = oh[DIM_FLD_W-1:0];
		if (!mat_full) begin
			res.status = STATUS_NOT_READY;
			return;
		end
		r = out_row;
		c = out_col;
		// (x, y) is the source column and row of output position (c, r)
		case (m_rot)
			ROT_90: begin
				x = r;
				y = h - 1 - c;
			end
			ROT_180: begin
				x = w - 1 - c;
				y = h - 1 - r;
			end
			ROT_270: begin
				x = w - 1 - r;
				y = c;
			end
			default: begin
				x = c;
				y = r;
			end
		endcase
		fin        = (r + 1 >= oh) && (c + 1 >= ow);
		res.elem   = mat_store[y * w + x];
		res.last   = fin;
		res.status = STATUS_OK;
		if (fin) begin
			restart_fill();
		end else if (c + 1 >= ow) begin
			out_col = 0;
			out_row = r + 1;
		end else begin
			out_col = c + 1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		n_fail++;
		if (n_fail <= PRINT_MAX)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic check_result(input rot_res_t got, input rot_res_t want);
		if (got.elem !== want.elem)
			report_mismatch($sformatf("elem_out %h, expected %h", got.elem, want.elem));
		if (got.width !== want.width)
			report_mismatch($sformatf("out_width %0d, expected %0d", got.width, want.width));
		if (got.height !== want.height)
			report_mismatch($sformatf("out_height %0d, expected %0d", got.height, want.height));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
		if (got.status !== want.status)
			report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
	endtask

	// Result beats are taken at the rising edge and matched against the
	// oldest pending element
	always @(posedge clk) begin : watch_results
		rot_res_t got;
		rot_res_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.elem   = res_ch.elem_out;
			got.width  = res_ch.out_width;
			got.height = res_ch.out_height;
			got.last   = res_ch.last;
			got.status = res_ch.status;
			if (rotated_elem_q.size() == 0) begin
				report_mismatch($sformatf("result beat %h with nothing pending", got.elem));
			end else begin
				want = rotated_elem_q.pop_front();
				check_result(got, want);
			end
		end
	end

	// Result side back-pressure: random stall bursts of random length, none
	// once the run has gone calm
	initial begin : stall_results
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_stall_on && !calm && $urandom_range(0, 3) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus. Every task below is entered and left at a falling edge,
	// so each input is assigned at most once per edge.
	// ------------------------------------------------------------------
	task automatic drive_beat(input logic cmd, input logic [VALUE_W-1:0] value,
			input bit typed, input rot_res_t want);
		int       gap;
		bit       produces;
		bit       stored;
		rot_res_t res;
		gap = 0;
		if (tx_idle_on && !calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.cmd   <= cmd;
		item_ch.value <= value;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		predict_rotation(cmd, value, produces, stored, res);
		if (produces)
			rotated_elem_q.push_back(typed ? want : res);
		// loads that the block drops while full do not count
		if (produces || stored)
			n_beats++;
		@(negedge clk);
	endtask

	task automatic send_load(input logic [VALUE_W-1:0] value);
		drive_beat(CMD_LOAD, value, 1'b0, '0);
	endtask

	task automatic send_emit();
		drive_beat(CMD_EMIT, $urandom(), 1'b0, '0);
	endtask

	// Hold the item side until every pending element is back, then wait
	// extra cycles for a trailing load to land
	task automatic wait_drain(input int extra);
		item_ch.valid <= 1'b0;
		@(negedge clk);
		while (rotated_elem_q.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		shadow_reg_write(idx, data);
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		plan_row_t row;
		row       = '{kind: ROW_REG, default: '0};
		row.idx   = idx;
		row.data  = data;
		plan_q.push_back(row);
	endfunction

	function automatic void plan_beat(input logic cmd, input logic [VALUE_W-1:0] value,
			input bit typed, input rot_res_t want);
		plan_row_t row;
		row       = '{kind: ROW_BEAT, default: '0};
		row.cmd   = cmd;
		row.value = value;
		row.typed = typed;
		row.want  = want;
		plan_q.push_back(row);
	endfunction

	function automatic logic [DIM_FLD_W-1:0] rand_dim();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return DIM_FLD_W'($urandom_range(7, 16));
			default: return DIM_FLD_W'($urandom_range(1, 6));
		endcase
	endfunction

	// One random phase: set the shape and turn, fill the store, read the
	// rotated matrix out. Partial phases stop short of a full load and leave
	// the block mid-fill for the next reconfiguration to discard.
	task automatic run_phase(input logic [DIM_FLD_W-1:0] w_raw,
			input logic [DIM_FLD_W-1:0] h_raw, input bit allow_partial);
		int unsigned           need;
		int unsigned           loads;
		int unsigned           n_emit;
		int unsigned           drain_at;
		int unsigned           turn_at;
		bit                    partial;
		bit                    turn;
		logic [CFG_DATA_W-1:0] rot_data;
		wait_drain(SETTLE);
		tx_idle_on  = $urandom_range(0, 2) != 0;
		rx_stall_on = $urandom_range(0, 2) != 0;
		reg_write(REG_IN_WIDTH, w_raw);
		reg_write(REG_IN_HEIGHT, h_raw);
		// upper data bits are junk for the rotation register
		rot_data = CFG_DATA_W'($urandom_range(0, 127));
		reg_write(REG_ROTATION, rot_data);
		if ($urandom_range(0, 5) == 0)
			reg_write(REG_SPARE, CFG_DATA_W'($urandom_range(0, 127)));

		need     = clamp_dim(w_raw) * clamp_dim(h_raw);
		partial  = allow_partial && $urandom_range(0, 7) == 0;
		loads    = partial ? $urandom_range(0, need - 1) : need;
		drain_at = $urandom_range(0, need - 1);
		for (int unsigned k = 0; k < loads; k++) begin
			// the odd early emit gets the not-ready answer
			if ($urandom_range(0, 15) == 0)
				send_emit();
			if (k == drain_at)
				wait_drain(0);
			send_load($urandom());
		end
		if (partial) begin
			repeat ($urandom_range(1, 3)) send_emit();
			return;
		end
		// loads into a full store are dropped
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 2)) send_load($urandom());

		// now and then change the turn part-way through the read-out
		turn    = need > 1 && $urandom_range(0, 3) == 0;
		turn_at = $urandom_range(1, need - 1);
		n_emit  = 0;
		while (mat_full) begin
			if (turn && n_emit == turn_at) begin
				wait_drain(SETTLE);
				rot_data = CFG_DATA_W'($urandom_range(0, 127));
				reg_write(REG_ROTATION, rot_data);
				turn = 1'b0;
			end
			send_emit();
			n_emit++;
		end
	endtask

	initial begin : watchdog
		#(LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : run_test
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd   = CMD_LOAD;
		item_ch.value = '0;
		res_ch.ready  = 1'b0;
		n_fail        = 0;
		n_beats       = 0;
		tx_idle_on    = 1'b1;
		rx_stall_on   = 1'b1;
		calm          = 1'b0;
		m_width       = 7'd1;
		m_height      = 7'd1;
		m_rot         = ROT_0;
		restart_fill();

		// Directed table. Rows with a typed-in element are worked out by
		// hand; the rest go through the shadow model.
		plan_reg(REG_SPARE, 7'h7F);
		// after reset: 1 x 1, nothing loaded yet
		plan_beat(CMD_EMIT, 32'h0, 1'b1,
			rot_res_t'{32'h0, 7'd1, 7'd1, 1'b0, STATUS_NOT_READY});
		plan_beat(CMD_LOAD, 32'hFFFF_FFFF, 1'b0, '0);
		// store already full, this one is dropped
		plan_beat(CMD_LOAD, 32'h0000_0000, 1'b0, '0);
		plan_beat(CMD_EMIT, 32'hFFFF_FFFF, 1'b1,
			rot_res_t'{32'hFFFF_FFFF, 7'd1, 7'd1, 1'b1, STATUS_OK});
		// last element sends the block back to loading
		plan_beat(CMD_EMIT, 32'h0, 1'b1,
			rot_res_t'{32'h0, 7'd1, 7'd1, 1'b0, STATUS_NOT_READY});
		plan_reg(REG_IN_WIDTH, 7'd3);
		plan_reg(REG_IN_HEIGHT, 7'd2);
		plan_reg(REG_ROTATION, {5'b0, ROT_90});
		// not ready still reports the turned shape: 2 wide, 3 high
		plan_beat(CMD_EMIT, 32'h0, 1'b1,
			rot_res_t'{32'h0, 7'd2, 7'd3, 1'b0, STATUS_NOT_READY});
		for (int i = 1; i <= 6; i++)
			plan_beat(CMD_LOAD, 32'h1111_1111 * i, 1'b0, '0);
		plan_beat(CMD_EMIT, 32'h0, 1'b0, '0);
		plan_beat(CMD_EMIT, 32'h0, 1'b0, '0);
		// new turn mid read-out: data stays, read-out restarts
		plan_reg(REG_ROTATION, {5'b10101, ROT_270});
		for (int i = 0; i < 6; i++)
			plan_beat(CMD_EMIT, 32'h0, 1'b0, '0);
		plan_beat(CMD_EMIT, 32'h0, 1'b1,
			rot_res_t'{32'h0, 7'd2, 7'd3, 1'b0, STATUS_NOT_READY});
		// width 0 behaves as 1; a 1 x 2 column turned half way round
		plan_reg(REG_ROTATION, {5'b0, ROT_180});
		plan_reg(REG_IN_WIDTH, 7'd0);
		plan_beat(CMD_LOAD, 32'hAAAA_AAAA, 1'b0, '0);
		plan_beat(CMD_LOAD, 32'h5555_5555, 1'b0, '0);
		plan_beat(CMD_EMIT, 32'h0, 1'b1,
			rot_res_t'{32'h5555_5555, 7'd1, 7'd2, 1'b0, STATUS_OK});
		plan_beat(CMD_EMIT, 32'h0, 1'b1,
			rot_res_t'{32'hAAAA_AAAA, 7'd1, 7'd2, 1'b1, STATUS_OK});

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (plan_q[i]) begin
			if (plan_q[i].kind == ROW_REG) begin
				wait_drain(SETTLE);
				reg_write(plan_q[i].idx, plan_q[i].data);
			end else begin
				drive_beat(plan_q[i].cmd, plan_q[i].value, plan_q[i].typed, plan_q[i].want);
			end
		end

		// widest, clamped and tallest shapes, kept one-dimensional to stay short
		run_phase(7'd64, 7'd0, 1'b0);
		run_phase(7'd127, 7'd1, 1'b0);
		run_phase(7'd1, 7'd127, 1'b0);

		while (n_beats < BEAT_GOAL) begin
			if (n_beats >= CALM_FROM)
				calm = 1'b1;
			run_phase(rand_dim(), rand_dim(), 1'b1);
		end

		wait_drain(4 * SETTLE);
		if (n_fail == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
